### rtl/core/tfvc_pkg.sv
// Shared types, constants and tables of the target follow velocity controller.
`default_nettype none
package tfvc_pkg;

    // CORDIC sizing
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int N_CELLS      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Smoothing rates, per second
    localparam logic [7:0] DECAY_RATE_LIN  = 8'd3;
    localparam logic [7:0] DECAY_RATE_ANG  = 8'd15;
    localparam logic [7:0] INJECT_RATE_LIN = 8'd6;
    localparam logic [7:0] INJECT_RATE_ANG = 8'd20;

    // Fixed-point constants
    localparam logic signed [33:0] PI_Q30   = 34'sd3373259426;
    localparam logic [29:0]        INV_GAIN = 30'h26DD3B6A;
    localparam logic [30:0]        Q30_ONE  = 31'h4000_0000;
    // ceil(2^30 / 1000), exact floor division of values below 2^20
    localparam logic [20:0]        M1000    = 21'd1073742;

    // Configuration register indexes
    localparam logic [2:0] CFG_RANGE_TARGET   = 3'd0;
    localparam logic [2:0] CFG_BEARING_TARGET = 3'd1;
    localparam logic [2:0] CFG_RANGE_GAIN     = 3'd2;
    localparam logic [2:0] CFG_BEARING_GAIN   = 3'd3;
    localparam logic [2:0] CFG_LINEAR_LIMIT   = 3'd4;
    localparam logic [2:0] CFG_TURN_LIMIT     = 3'd5;
    localparam logic [2:0] CFG_NEAR_LIMIT     = 3'd6;

    // Vector travelling down the CORDIC row
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cord;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] atan_q30(input logic [4:0] idx);
        logic [30:0] v;
        case (idx)
            5'd0:  v = 31'h3243F6A8;
            5'd1:  v = 31'h1DAC6705;
            5'd2:  v = 31'h0FADBAFC;
            5'd3:  v = 31'h07F56EA6;
            5'd4:  v = 31'h03FEAB76;
            5'd5:  v = 31'h01FFD55B;
            5'd6:  v = 31'h00FFFAAA;
            5'd7:  v = 31'h007FFF55;
            5'd8:  v = 31'h003FFFEA;
            5'd9:  v = 31'h001FFFFD;
            5'd10: v = 31'h000FFFFF;
            5'd11: v = 31'h0007FFFF;
            5'd12: v = 31'h0003FFFF;
            5'd13: v = 31'h0001FFFF;
            5'd14: v = 31'h0000FFFF;
            5'd15: v = 31'h00007FFF;
            5'd16: v = 31'h00003FFF;
            5'd17: v = 31'h00001FFF;
            5'd18: v = 31'h00000FFF;
            5'd19: v = 31'h000007FF;
            5'd20: v = 31'h000003FF;
            5'd21: v = 31'h000001FF;
            5'd22: v = 31'h000000FF;
            5'd23: v = 31'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // ceil(2^34 / k): floor(p / k) = (p * m) >> 34 for p <= 2^30
    function automatic logic [33:0] recip_k(input logic [3:0] k);
        logic [33:0] m;
        case (k)
            4'd2:  m = 34'd8589934592;
            4'd3:  m = 34'd5726623062;
            4'd4:  m = 34'd4294967296;
            4'd5:  m = 34'd3435973837;
            4'd6:  m = 34'd2863311531;
            4'd7:  m = 34'd2454267027;
            4'd8:  m = 34'd2147483648;
            4'd9:  m = 34'd1908874354;
            4'd10: m = 34'd1717986919;
            4'd11: m = 34'd1561806290;
            4'd12: m = 34'd1431655766;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### rtl/core/tfvc_tgt_if.sv
// Target position channel: valid, ready and one target item.
`default_nettype none
interface tfvc_tgt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [15:0] gap_ms;

    modport source (output valid, target_x, target_y, gap_ms, input ready);
    modport sink   (input valid, target_x, target_y, gap_ms, output ready);
endinterface
`default_nettype wire

### rtl/core/tfvc_cmd_if.sv
// Velocity command channel: valid, ready and one command item.
`default_nettype none
interface tfvc_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] linear_cmd;
    logic signed [15:0] turn_cmd;

    modport source (output valid, linear_cmd, turn_cmd, input ready);
    modport sink   (input valid, linear_cmd, turn_cmd, output ready);
endinterface
`default_nettype wire

### rtl/core/target_follow_velocity_controller.sv
// An item passes through the CORDIC row and then the ratio units: two 12-term series,
// then up to 11 power steps; a long gap or a vanishing ratio skips the series and the
// power steps.
// One item at a time: the next is taken the cycle after the result is loaded, and the
// final step waits while the output register is held full.
// Synchronous active-low reset clears held commands and loads default configuration.
`default_nettype none
module target_follow_velocity_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tfvc_tgt_if.sink    i_tgt,
    tfvc_cmd_if.source  o_cmd
);
    import tfvc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_RNG  = 3'd2;
    localparam logic [2:0] ST_CMD  = 3'd3;
    localparam logic [2:0] ST_RAT  = 3'd4;
    localparam logic [2:0] ST_BLND = 3'd5;
    localparam logic [2:0] ST_SUM  = 3'd6;

    // configuration
    logic [15:0]        r_range_target;
    logic signed [15:0] r_bearing_target;
    logic [15:0]        r_range_gain;
    logic [15:0]        r_bearing_gain;
    logic [14:0]        r_linear_limit;
    logic [14:0]        r_turn_limit;
    logic [15:0]        r_near_limit;

    logic [2:0]         r_state;
    logic [15:0]        r_t;
    t_cord              r_feed;
    t_cord              n_feed;
    t_cord              w_chain [0:N_CELLS];
    logic [62:0]        r_rng_prod;
    logic signed [33:0] r_z;
    logic               r_zero;
    logic [15:0]        r_range;
    logic signed [16:0] r_bearing;
    logic signed [33:0] r_lin_prod;
    logic signed [34:0] r_ang_prod;
    logic               r_near;
    logic signed [15:0] r_cmd_lin;
    logic signed [15:0] r_cmd_ang;
    logic [15:0]        r_rl;
    logic [15:0]        r_ra;
    logic signed [33:0] r_bl_la;
    logic signed [33:0] r_bl_lb;
    logic signed [33:0] r_bl_aa;
    logic signed [33:0] r_bl_ab;
    logic signed [15:0] r_held_lin;
    logic signed [15:0] r_held_ang;
    logic               r_out_valid;
    logic signed [15:0] r_out_lin;
    logic signed [15:0] r_out_ang;

    logic               w_accept;
    logic signed [16:0] w_x17;
    logic signed [16:0] w_y17;
    logic [62:0]        w_rng_rnd;
    logic [18:0]        w_rng;
    logic signed [33:0] w_bear;
    logic signed [16:0] w_rdiff;
    logic signed [17:0] w_bdiff;
    logic signed [33:0] w_lin_sh;
    logic signed [34:0] w_ang_sh;
    logic signed [33:0] w_lin_lim;
    logic signed [34:0] w_ang_lim;
    logic signed [15:0] w_lin_cl;
    logic signed [15:0] w_ang_cl;
    logic               w_near_now;
    logic               w_rat_start;
    logic               w_rl_done;
    logic               w_ra_done;
    logic [15:0]        w_rl;
    logic [15:0]        w_ra;
    logic signed [34:0] w_sum_lin;
    logic signed [34:0] w_sum_ang;
    logic               w_out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_target   <= 16'd256;
            r_bearing_target <= 16'sd0;
            r_range_gain     <= 16'd256;
            r_bearing_gain   <= 16'd512;
            r_linear_limit   <= 15'd1229;
            r_turn_limit     <= 15'd6144;
            r_near_limit     <= 16'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_TARGET:   r_range_target   <= i_cfg_data;
                CFG_BEARING_TARGET: r_bearing_target <= signed'(i_cfg_data);
                CFG_RANGE_GAIN:     r_range_gain     <= i_cfg_data;
                CFG_BEARING_GAIN:   r_bearing_gain   <= i_cfg_data;
                CFG_LINEAR_LIMIT:   r_linear_limit   <= i_cfg_data[14:0];
                CFG_TURN_LIMIT:     r_turn_limit     <= i_cfg_data[14:0];
                CFG_NEAR_LIMIT:     r_near_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_tgt.ready = (r_state == ST_IDLE);
    assign w_accept    = i_tgt.valid && i_tgt.ready;

    // quadrant fold and scaling into the CORDIC row
    always_comb begin
        w_x17        = {i_tgt.target_x[15], i_tgt.target_x};
        w_y17        = {i_tgt.target_y[15], i_tgt.target_y};
        n_feed       = '0;
        n_feed.valid = w_accept;
        n_feed.zero  = (w_x17 == 17'sd0) && (w_y17 == 17'sd0);
        if (w_x17 < 0) begin
            n_feed.z = (w_y17 >= 0) ? PI_Q30 : -PI_Q30;
            w_x17    = -w_x17;
            w_y17    = -w_y17;
        end
        n_feed.x = {{3{w_x17[16]}}, w_x17, 14'b0};
        n_feed.y = {{3{w_y17[16]}}, w_y17, 14'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed <= '0;
        end else begin
            r_feed <= n_feed;
        end
    end

    // CORDIC row
    assign w_chain[0] = r_feed;
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        tfvc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (5'(g)),
            .i_cord  (w_chain[g]),
            .o_cord  (w_chain[g+1])
        );
    end

    // range, bearing, proportional commands
    always_comb begin
        w_rng_rnd  = (r_rng_prod + (63'(1) << 43)) >> 44;
        w_rng      = w_rng_rnd[18:0];
        w_bear     = (r_z + 34'sd65536) >>> 17;
        w_rdiff    = signed'({1'b0, r_range}) - signed'({1'b0, r_range_target});
        w_bdiff    = {r_bearing[16], r_bearing}
                   - {{2{r_bearing_target[15]}}, r_bearing_target};
        w_near_now = r_range < r_near_limit;
        w_lin_sh   = (r_lin_prod + 34'sd8) >>> 4;
        w_ang_sh   = (r_ang_prod + 35'sd256) >>> 9;
        w_lin_lim  = signed'({19'b0, r_linear_limit});
        w_ang_lim  = signed'({20'b0, r_turn_limit});
        if (w_lin_sh > w_lin_lim) begin
            w_lin_cl = w_lin_lim[15:0];
        end else if (w_lin_sh < -w_lin_lim) begin
            w_lin_cl = 16'(-w_lin_lim);
        end else begin
            w_lin_cl = w_lin_sh[15:0];
        end
        if (w_ang_sh > w_ang_lim) begin
            w_ang_cl = w_ang_lim[15:0];
        end else if (w_ang_sh < -w_ang_lim) begin
            w_ang_cl = 16'(-w_ang_lim);
        end else begin
            w_ang_cl = w_ang_sh[15:0];
        end
        w_sum_lin  = 35'(r_bl_la) + 35'(r_bl_lb) + 35'sd32768;
        w_sum_ang  = 35'(r_bl_aa) + 35'(r_bl_ab) + 35'sd32768;
    end

    assign w_rat_start = (r_state == ST_CMD);
    assign w_out_free  = !r_out_valid || o_cmd.ready;

    // ratio units, one per command
    tfvc_ratio u_ratio_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rat_start),
        .i_rate  (w_near_now ? DECAY_RATE_LIN : INJECT_RATE_LIN),
        .i_t     (r_t),
        .o_done  (w_rl_done),
        .o_ratio (w_rl)
    );

    tfvc_ratio u_ratio_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rat_start),
        .i_rate  (w_near_now ? DECAY_RATE_ANG : INJECT_RATE_ANG),
        .i_t     (r_t),
        .o_done  (w_ra_done),
        .o_ratio (w_ra)
    );

    // item sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held_lin  <= '0;
            r_held_ang  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loaded by the final step, emptied by a transfer
            if ((r_state == ST_SUM) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_t     <= i_tgt.gap_ms;
                        r_state <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (w_chain[N_CELLS].valid) begin
                        r_rng_prod <= {30'b0, w_chain[N_CELLS].x[32:0]} * {33'b0, INV_GAIN};
                        r_z        <= w_chain[N_CELLS].z;
                        r_zero     <= w_chain[N_CELLS].zero;
                        r_state    <= ST_RNG;
                    end
                end
                ST_RNG: begin
                    if (r_zero) begin
                        r_range   <= '0;
                        r_bearing <= '0;
                    end else begin
                        r_range   <= (w_rng > 19'd65535) ? 16'hFFFF : w_rng[15:0];
                        r_bearing <= w_bear[16:0];
                    end
                    r_state <= ST_CMD;
                end
                ST_CMD: begin
                    r_lin_prod <= w_rdiff * signed'({1'b0, r_range_gain});
                    r_ang_prod <= w_bdiff * signed'({1'b0, r_bearing_gain});
                    r_near     <= w_near_now;
                    r_state    <= ST_RAT;
                end
                ST_RAT: begin
                    if (w_rl_done && w_ra_done) begin
                        r_cmd_lin <= r_near ? 16'sd0 : w_lin_cl;
                        r_cmd_ang <= r_near ? 16'sd0 : w_ang_cl;
                        r_rl      <= w_rl;
                        r_ra      <= w_ra;
                        r_state   <= ST_BLND;
                    end
                end
                ST_BLND: begin
                    r_bl_la <= r_cmd_lin * signed'({1'b0, 17'h10000 - {1'b0, r_rl}});
                    r_bl_lb <= r_held_lin * signed'({1'b0, r_rl});
                    r_bl_aa <= r_cmd_ang * signed'({1'b0, 17'h10000 - {1'b0, r_ra}});
                    r_bl_ab <= r_held_ang * signed'({1'b0, r_ra});
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (w_out_free) begin
                        r_held_lin  <= w_sum_lin[31:16];
                        r_held_ang  <= w_sum_ang[31:16];
                        r_out_lin   <= w_sum_lin[31:16];
                        r_out_ang   <= w_sum_ang[31:16];
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cmd.valid      = r_out_valid;
    assign o_cmd.linear_cmd = r_out_lin;
    assign o_cmd.turn_cmd   = r_out_ang;

`ifndef NO_ASSERTIONS
    // a result appears only from the final blend step
    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SUM))
        else $error("result raised outside final step");

    // an accepted item always enters the CORDIC wait
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CORD))
        else $error("accepted item did not start");

    // the CORDIC row only delivers while its result is awaited
    a_chain_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[N_CELLS].valid |-> (r_state == ST_CORD))
        else $error("CORDIC output with no item waiting");
`endif
endmodule
`default_nettype wire

### rtl/core/tfvc_cordic_cell.sv
// One CORDIC vectoring cell: a single micro-rotation, registered.
`default_nettype none
module tfvc_cordic_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_idx,
    input  tfvc_pkg::t_cord i_cord,
    output tfvc_pkg::t_cord o_cord
);
    import tfvc_pkg::*;

    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic signed [33:0] w_atan;
    t_cord              n_cord;
    t_cord              r_cord;

    // rotate towards the x axis
    always_comb begin
        w_dx   = i_cord.y >>> i_idx;
        w_dy   = i_cord.x >>> i_idx;
        w_atan = signed'({3'b000, atan_q30(i_idx)});
        n_cord = i_cord;
        if (i_cord.y >= 0) begin
            n_cord.x = i_cord.x + w_dx;
            n_cord.y = i_cord.y - w_dy;
            n_cord.z = i_cord.z + w_atan;
        end else begin
            n_cord.x = i_cord.x - w_dx;
            n_cord.y = i_cord.y + w_dy;
            n_cord.z = i_cord.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cord <= '0;
        end else begin
            r_cord <= n_cord;
        end
    end

    assign o_cord = r_cord;
endmodule
`default_nettype wire

### rtl/core/tfvc_ratio.sv
// Smoothing ratio exp(-rate*t/1000) as unsigned Q0.16, computed step by step.
`default_nettype none
module tfvc_ratio (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_rate,
    input  logic [15:0] i_t,
    output logic        o_done,
    output logic [15:0] o_ratio
);
    import tfvc_pkg::*;

    localparam logic [3:0] R_IDLE = 4'd0;
    localparam logic [3:0] R_E    = 4'd1;
    localparam logic [3:0] R_NQ   = 4'd2;
    localparam logic [3:0] R_NR   = 4'd3;
    localparam logic [3:0] R_XA   = 4'd4;
    localparam logic [3:0] R_XB   = 4'd5;
    localparam logic [3:0] R_SA   = 4'd6;
    localparam logic [3:0] R_SB   = 4'd7;
    localparam logic [3:0] R_POW  = 4'd8;
    localparam logic [3:0] R_FIN  = 4'd9;
    localparam logic [3:0] R_DONE = 4'd10;

    logic [3:0]  r_state;
    logic [7:0]  r_rate;
    logic [15:0] r_t;
    logic        r_long;
    logic [19:0] r_e;
    logic [40:0] r_nprod;
    logic [3:0]  r_n;
    logic [9:0]  r_r;
    logic [40:0] r_xprod;
    logic [30:0] r_xarg;
    logic [30:0] r_sx;
    logic [30:0] r_s;
    logic [30:0] r_p;
    logic [3:0]  r_k;
    logic        r_phase;
    logic [30:0] r_e1;
    logic [30:0] r_v;
    logic [3:0]  r_cnt;
    logic [15:0] r_ratio;

    logic [10:0] w_n;
    logic [19:0] w_nk;
    logic [19:0] w_rem;
    logic [19:0] w_xnum;
    logic [61:0] w_ms;
    logic [64:0] w_mq;
    logic [30:0] w_q;
    logic [30:0] w_snext;
    logic [61:0] w_mv;
    logic [31:0] w_fin;

    // quotient, remainder and series arithmetic
    always_comb begin
        w_n     = r_nprod[40:30];
        w_nk    = 20'(21'(w_n) * 21'd1000);
        w_rem   = r_e - w_nk;
        w_xnum  = 20'(r_r) * 20'd824 + 20'd500;
        w_ms    = 62'(r_sx) * 62'(r_s);
        w_mq    = 65'(r_p) * 65'(recip_k(r_k));
        w_q     = (r_k == 4'd1) ? r_p : w_mq[64:34];
        w_snext = Q30_ONE - w_q;
        w_mv    = 62'(r_v) * 62'(r_e1) + (62'(1) << 29);
        w_fin   = (32'(r_v) + 32'd8192) >> 14;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            unique case (r_state)
                R_IDLE, R_DONE: begin
                    if (i_start) begin
                        r_rate  <= i_rate;
                        r_t     <= i_t;
                        r_state <= R_E;
                    end
                end
                R_E: begin
                    r_long  <= |r_t[15:12];
                    r_e     <= 20'(r_rate) * 20'(r_t[11:0]);
                    r_state <= R_NQ;
                end
                R_NQ: begin
                    r_nprod <= 41'(r_e) * 41'(M1000);
                    r_state <= R_NR;
                end
                R_NR: begin
                    r_n <= w_n[3:0];
                    r_r <= w_rem[9:0];
                    if (r_long || (w_n >= 11'd12)) begin
                        r_v     <= '0;
                        r_state <= R_FIN;
                    end else begin
                        r_state <= R_XA;
                    end
                end
                R_XA: begin
                    r_xprod <= 41'(w_xnum) * 41'(M1000);
                    r_state <= R_XB;
                end
                R_XB: begin
                    r_xarg  <= 31'(r_r) * 31'd1073741 + 31'(r_xprod[40:30]);
                    r_sx    <= Q30_ONE;
                    r_s     <= Q30_ONE;
                    r_k     <= 4'd12;
                    r_phase <= 1'b0;
                    r_state <= R_SA;
                end
                R_SA: begin
                    r_p     <= w_ms[60:30];
                    r_state <= R_SB;
                end
                R_SB: begin
                    if (r_k == 4'd1) begin
                        if (!r_phase) begin
                            // exp(-1) done, now the fractional part
                            r_e1    <= w_snext;
                            r_phase <= 1'b1;
                            r_sx    <= r_xarg;
                            r_s     <= Q30_ONE;
                            r_k     <= 4'd12;
                            r_state <= R_SA;
                        end else begin
                            r_v     <= w_snext;
                            r_cnt   <= '0;
                            r_state <= R_POW;
                        end
                    end else begin
                        r_s     <= w_snext;
                        r_k     <= r_k - 4'd1;
                        r_state <= R_SA;
                    end
                end
                R_POW: begin
                    if (r_cnt == r_n) begin
                        r_state <= R_FIN;
                    end else begin
                        r_v   <= w_mv[60:30];
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                R_FIN: begin
                    r_ratio <= (w_fin > 32'd65535) ? 16'hFFFF : w_fin[15:0];
                    r_state <= R_DONE;
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == R_DONE);
    assign o_ratio = r_ratio;
endmodule
`default_nettype wire
